### rtl/core/twl_pkg.sv
// Package for the transpose word list core.
// Holds the stream widths, request codes and the sequencer state type.
// No dependencies.
package twl_pkg;

    // Widest word carried on the input stream: 20 bytes.
    localparam int WORD_MAX_BYTES = 20;
    localparam int WORD_MAX_BITS  = 8 * WORD_MAX_BYTES;

    // Stream widths
    localparam int S_DATA_W = WORD_MAX_BITS;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 1;

    // Result field widths
    localparam int POS_W   = 3;
    localparam int COUNT_W = 3;

    // Request kinds carried in s_tuser
    localparam logic REQ_UP   = 1'b0;
    localparam logic REQ_DOWN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_NB_READ,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_APPEND,
        ST_DONE
    } twl_state_t;

endpackage

### rtl/core/transpose_word_list_core.sv
// Transpose word list core: self-organizing table of words, transpose rule.
// Depends on twl_pkg.
//
// The core keeps an ordered table of up to ENTRIES words of WORD_BYTES bytes
// and moves a named word one place toward the front (up) or the back (down)
// per request. An up request on an absent word appends it, or overwrites the
// last entry once the table is full; a down request on an absent word reports
// not found. Each word on the input stream gives exactly one result word.
// One request is worked at a time: the core accepts a word, then scans the
// table with a single 8*WORD_BYTES-bit equality comparator, one entry at a
// time, each read in ST_READ and compared in ST_CMP (one-port table memory
// with a registered read), then does the swap (neighbor read plus two
// writes) or the append. A request on an empty table skips the scan.
// s_tready stays low from acceptance until the request is through. The
// finished request also waits in ST_DONE for as long as the previous result
// is still held in the output register. The result sits in that output
// register, so the next request can be taken while it waits.
// The table memory needs no clearing after reset: only entries below the
// stored count are ever read.
module transpose_word_list_core #(
    parameter int ENTRIES    = 6,
    parameter int WORD_BYTES = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [63:0] word_lo, [127:64] word_mid, [159:128] word_hi
    input  logic [twl_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic [twl_pkg::S_USER_W-1:0]  s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] position, [5:3] entry_count, [7:6] zero
    output logic [twl_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] not_found
    output logic [twl_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int WORD_BITS = 8 * WORD_BYTES;
    localparam int IW        = $clog2(ENTRIES);
    localparam int CW        = $clog2(ENTRIES + 1);

    twl_pkg::twl_state_t state_reg, state_next;

    // Request registers
    logic [WORD_BITS-1:0] word_reg;
    logic                 down_reg;

    // Scan and sequencing registers
    logic [IW-1:0]        idx_reg;     // scan index, then the matched entry
    logic [IW-1:0]        nb_reg;      // swap partner or append slot
    logic                 found_reg;
    logic [CW-1:0]        count_reg;

    // Result being built
    logic [IW-1:0]        pos_reg;
    logic                 nf_reg;

    // Output register
    logic                 out_valid_reg;
    logic [twl_pkg::POS_W-1:0]   out_pos_reg;
    logic [twl_pkg::COUNT_W-1:0] out_count_reg;
    logic                 out_nf_reg;

    // Table memory, one port, registered read
    logic [WORD_BITS-1:0] table_mem [ENTRIES];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Shared compare and index tests
    logic                 match;
    logic                 scan_last;
    logic                 at_front;
    logic                 has_next;
    logic                 full;
    logic                 out_free;
    logic                 accept;

    assign match     = (rd_data_reg == word_reg);
    assign scan_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign at_front  = (idx_reg == '0);
    assign has_next  = ((CW'(idx_reg) + CW'(1)) < count_reg);
    assign full      = (count_reg == CW'(ENTRIES));
    assign out_free  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg == '0) ? twl_pkg::ST_DECIDE
                                                   : twl_pkg::ST_READ;
                end
            end
            twl_pkg::ST_READ:
            begin
                state_next = twl_pkg::ST_CMP;
            end
            twl_pkg::ST_CMP:
            begin
                if (match || scan_last)
                    state_next = twl_pkg::ST_DECIDE;
                else
                    state_next = twl_pkg::ST_READ;
            end
            twl_pkg::ST_DECIDE:
            begin
                if (!found_reg)
                begin
                    state_next = (down_reg == twl_pkg::REQ_DOWN) ? twl_pkg::ST_DONE
                                                                 : twl_pkg::ST_APPEND;
                end
                else if (down_reg == twl_pkg::REQ_DOWN)
                begin
                    state_next = has_next ? twl_pkg::ST_NB_READ : twl_pkg::ST_DONE;
                end
                else
                begin
                    state_next = at_front ? twl_pkg::ST_DONE : twl_pkg::ST_NB_READ;
                end
            end
            twl_pkg::ST_NB_READ:
            begin
                state_next = twl_pkg::ST_SWAP_A;
            end
            twl_pkg::ST_SWAP_A:
            begin
                state_next = twl_pkg::ST_SWAP_B;
            end
            twl_pkg::ST_SWAP_B:
            begin
                state_next = twl_pkg::ST_DONE;
            end
            twl_pkg::ST_APPEND:
            begin
                state_next = twl_pkg::ST_DONE;
            end
            twl_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = twl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = twl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and memory port controls
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        wr_addr  = nb_reg;
        wr_data  = word_reg;
        unique case (state_reg)
            twl_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            twl_pkg::ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            twl_pkg::ST_NB_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = nb_reg;
            end
            twl_pkg::ST_SWAP_A:
            begin
                // matched entry equals the request word: it goes to the partner
                wr_en   = 1'b1;
                wr_addr = nb_reg;
                wr_data = word_reg;
            end
            twl_pkg::ST_SWAP_B:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
            end
            twl_pkg::ST_APPEND:
            begin
                wr_en   = 1'b1;
                wr_addr = nb_reg;
                wr_data = word_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= table_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twl_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == twl_pkg::ST_APPEND && !full)
                count_reg <= count_reg + CW'(1);
            if (state_reg == twl_pkg::ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            twl_pkg::ST_IDLE:
            begin
                word_reg  <= s_tdata[WORD_BITS-1:0];
                down_reg  <= s_tuser[0];
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            twl_pkg::ST_CMP:
            begin
                if (match)
                    found_reg <= 1'b1;
                else if (!scan_last)
                    idx_reg <= idx_reg + IW'(1);
            end
            twl_pkg::ST_DECIDE:
            begin
                nf_reg <= 1'b0;
                if (!found_reg)
                begin
                    if (down_reg == twl_pkg::REQ_DOWN)
                    begin
                        nf_reg  <= 1'b1;
                        pos_reg <= '0;
                    end
                    else
                    begin
                        // append slot: end of table, or last entry when full
                        nb_reg  <= full ? IW'(ENTRIES - 1) : count_reg[IW-1:0];
                        pos_reg <= full ? IW'(ENTRIES - 1) : count_reg[IW-1:0];
                    end
                end
                else if (down_reg == twl_pkg::REQ_DOWN)
                begin
                    nb_reg  <= idx_reg + IW'(1);
                    pos_reg <= has_next ? idx_reg + IW'(1) : idx_reg;
                end
                else
                begin
                    nb_reg  <= idx_reg - IW'(1);
                    pos_reg <= at_front ? idx_reg : idx_reg - IW'(1);
                end
            end
            twl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_pos_reg   <= twl_pkg::POS_W'(pos_reg);
                    out_count_reg <= twl_pkg::COUNT_W'(count_reg);
                    out_nf_reg    <= nf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_pos_reg};
    assign m_tuser  = out_nf_reg;

endmodule

### rtl/core/twl_checker.sv
// Port-level checker for the transpose word list core, with its bind.
// Depends on twl_pkg and transpose_word_list_core.
module twl_checker #(
    parameter int ENTRIES = 6
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [twl_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [twl_pkg::S_USER_W-1:0]  s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [twl_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [twl_pkg::M_USER_W-1:0]  m_tuser
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // One request at a time: the input closes after each accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after accept");

    // A not-found result reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[2:0] == 3'd0)
    else $error("not-found result with nonzero position");

    // A found or stored word sits inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && ENTRIES <= 7 |-> m_tdata[2:0] < m_tdata[5:3])
    else $error("position outside the stored count");

    // Entry count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ENTRIES <= 7 |-> m_tdata[5:3] <= 3'(ENTRIES))
    else $error("entry count above table size");

endmodule

bind transpose_word_list_core twl_checker #(.ENTRIES(ENTRIES)) u_twl_checker (.*);
